// ===== rtl/fprp_pkg.sv =====
// ----------------------------------------------------------------------------
// fprp_pkg
// Shared types and constants for the passive-mode reply parser.
// ----------------------------------------------------------------------------
package fprp_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] SAT_MAX  = 8'd255;

  localparam int unsigned NUM_SAVED = 5;
  localparam int unsigned SAVE_IDX_W = $clog2(NUM_SAVED);

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_NUM1   = 3'd1,
    PH_NUM2   = 3'd2,
    PH_NUM3   = 3'd3,
    PH_NUM4   = 3'd4,
    PH_NUM5   = 3'd5,
    PH_NUM6   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0]  host_a;
    logic [7:0]  host_b;
    logic [7:0]  host_c;
    logic [7:0]  host_d;
    logic [15:0] data_port;
    logic        overflow;
  } result_t;

endpackage

// ===== rtl/fprp_if.sv =====
// ----------------------------------------------------------------------------
// fprp_if
// Valid/ready channels: reply bytes in, parsed address out.
// ----------------------------------------------------------------------------
interface fprp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fprp_addr_if;
  logic        valid;
  logic        ready;
  logic [7:0]  host_a;
  logic [7:0]  host_b;
  logic [7:0]  host_c;
  logic [7:0]  host_d;
  logic [15:0] data_port;
  logic        overflow;

  modport source (output valid, output host_a, output host_b, output host_c,
                  output host_d, output data_port, output overflow, input ready);
  modport sink   (input valid, input host_a, input host_b, input host_c,
                  input host_d, input data_port, input overflow, output ready);
endinterface

// ===== rtl/ftp_passive_reply_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ftp_passive_reply_parser_unit
// Extracts host address and data port from a passive-mode reply.
// ----------------------------------------------------------------------------
// Channels: rx carries one reply character per beat; addr carries one
// result per completed reply (four host bytes, port, overflow flag).
// Bytes before '(' are dropped. Six decimal numbers follow, separated by
// ','; other bytes are skipped. The ')' after the sixth number produces
// the result. Numbers saturate at 255 and set overflow.
// Throughput: one byte per cycle, sustained, while addr is not stalled.
// Path: a byte is registered in the input register and is parsed when
// the parser steps on it; the step on ')' also loads the result register,
// which raises addr valid and holds the result for the addr beat.
// Stall: while a result waits on addr, the parser holds; rx keeps taking
// a byte into the input register, then deasserts ready.
// Reset: clears phase, current number, saved numbers, overflow and both
// valid flags; the block searches for '(' afterwards.
// ----------------------------------------------------------------------------
module ftp_passive_reply_parser_unit (
  input  logic        clk,
  input  logic        rst,
  fprp_byte_if.sink   rx,
  fprp_addr_if.source addr
);
  import fprp_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       step;
  logic       emit;
  logic       busy;
  result_t    result;

  assign step = byte_valid && !busy;

  fprp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .take       (step),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  fprp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_data (byte_data),
    .emit      (emit),
    .result    (result)
  );

  fprp_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (step && emit),
    .data (result),
    .busy (busy),
    .addr (addr)
  );

endmodule

// ===== rtl/fprp_in_reg.sv =====
// ----------------------------------------------------------------------------
// fprp_in_reg
// Input register for reply bytes; holds one beat until the parser takes it.
// ----------------------------------------------------------------------------
module fprp_in_reg (
  input  logic       clk,
  input  logic       rst,
  fprp_byte_if.sink  rx,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  assign rx.ready = !byte_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      byte_data <= rx.rx_byte;
    end
  end

endmodule

// ===== rtl/fprp_parse.sv =====
// ----------------------------------------------------------------------------
// fprp_parse
// Reply state machine and number accumulation, one byte per step.
// ----------------------------------------------------------------------------
module fprp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       byte_data,
  output logic             emit,
  output fprp_pkg::result_t result
);
  import fprp_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] cur, cur_next;
  logic       ovf, ovf_next;
  logic [7:0] saved [NUM_SAVED];
  logic       save_en;

  logic                  is_digit;
  logic [3:0]            digit;
  logic [11:0]           acc;
  logic [SAVE_IDX_W-1:0] save_idx;

  assign is_digit = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);
  assign digit    = 4'(byte_data - CH_ZERO);
  assign acc      = 12'(cur) * 12'd10 + 12'(digit);
  assign save_idx = SAVE_IDX_W'(phase - 3'd1);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_SEARCH: if (byte_data == CH_OPEN) phase_next = PH_NUM1;
      PH_NUM1:   if (!is_digit && byte_data == CH_COMMA) phase_next = PH_NUM2;
      PH_NUM2:   if (!is_digit && byte_data == CH_COMMA) phase_next = PH_NUM3;
      PH_NUM3:   if (!is_digit && byte_data == CH_COMMA) phase_next = PH_NUM4;
      PH_NUM4:   if (!is_digit && byte_data == CH_COMMA) phase_next = PH_NUM5;
      PH_NUM5:   if (!is_digit && byte_data == CH_COMMA) phase_next = PH_NUM6;
      PH_NUM6:   if (!is_digit && byte_data == CH_CLOSE) phase_next = PH_SEARCH;
      default:   phase_next = PH_SEARCH;
    endcase
  end

  always_comb begin
    cur_next = cur;
    ovf_next = ovf;
    save_en  = 1'b0;
    emit     = 1'b0;
    unique case (phase)
      PH_NUM1, PH_NUM2, PH_NUM3, PH_NUM4, PH_NUM5, PH_NUM6: begin
        if (is_digit) begin
          if (acc > 12'(SAT_MAX)) begin
            cur_next = SAT_MAX;
            ovf_next = 1'b1;
          end else begin
            cur_next = acc[7:0];
          end
        end else if (phase != PH_NUM6 && byte_data == CH_COMMA) begin
          save_en  = 1'b1;
          cur_next = '0;
        end else if (phase == PH_NUM6 && byte_data == CH_CLOSE) begin
          emit     = 1'b1;
          cur_next = '0;
          ovf_next = 1'b0;
        end
      end
      default: begin
        if (byte_data == CH_OPEN) begin
          cur_next = '0;
          ovf_next = 1'b0;
        end
      end
    endcase
  end

  assign result.host_a    = saved[0];
  assign result.host_b    = saved[1];
  assign result.host_c    = saved[2];
  assign result.host_d    = saved[3];
  assign result.data_port = {saved[4], cur};
  assign result.overflow  = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      cur   <= '0;
      ovf   <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      cur   <= cur_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_SAVED; k++) begin
        saved[k] <= '0;
      end
    end else if (step && save_en) begin
      saved[save_idx] <= cur;
    end
  end

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> phase == PH_SEARCH && cur == '0 && !ovf)
    else $error("state not cleared after reply end");

  a_open_starts: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_SEARCH && byte_data == CH_OPEN |=> phase == PH_NUM1 && !ovf)
    else $error("open paren did not start a reply");

  a_ovf_on_digit: assert property (@(posedge clk) disable iff (rst)
    $rose(ovf) |-> $past(step && is_digit && phase != PH_SEARCH))
    else $error("overflow set without a digit");

  a_phase_moves_on_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(cur))
    else $error("parser state moved without a step");

endmodule

// ===== rtl/fprp_out_reg.sv =====
// ----------------------------------------------------------------------------
// fprp_out_reg
// Result register driving the address channel.
// ----------------------------------------------------------------------------
module fprp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  fprp_pkg::result_t data,
  output logic              busy,
  fprp_addr_if.source       addr
);
  import fprp_pkg::*;

  result_t held;

  assign busy = addr.valid && !addr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr.valid <= 1'b0;
    end else if (load) begin
      addr.valid <= 1'b1;
    end else if (addr.ready) begin
      addr.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

  assign addr.host_a    = held.host_a;
  assign addr.host_b    = held.host_b;
  assign addr.host_c    = held.host_c;
  assign addr.host_d    = held.host_d;
  assign addr.data_port = held.data_port;
  assign addr.overflow  = held.overflow;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !busy)
    else $error("result overwritten while stalled");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> addr.valid)
    else $error("loaded result not presented");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    addr.valid && addr.ready && !load |=> !addr.valid)
    else $error("result repeated after beat");

endmodule

// ===== test/ftp_passive_reply_parser_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftp_passive_reply_parser_unit_test
// Feeds passive-mode reply text into the parser byte by byte and checks
// every address beat it emits against an in-bench parser that tracks the
// same state. Directed replies cover empty and maximal numbers, saturation
// and stray separators. Random replies with noise, broken framing and
// random handshake idling follow, plus a long output stall.
// ----------------------------------------------------------------------------
module ftp_passive_reply_parser_unit_test;
  import fprp_pkg::*;

  logic clk;
  logic rst;

  fprp_byte_if rx_ch ();
  fprp_addr_if addr_ch ();

  ftp_passive_reply_parser_unit u_top (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx_ch),
    .addr (addr_ch)
  );

  // In-bench parser state
  phase_t     parse_phase;
  logic [7:0] cur_num;
  logic [7:0] saved_nums [NUM_SAVED];
  logic       ovf_seen;
  result_t    expected_addrs [$];

  int mismatches;
  int sent_bytes;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("ftp_passive_reply_parser_unit_test failed");
    $finish;
  end

  function automatic void parse_reply_byte(input logic [7:0] b);
    int acc;
    if (parse_phase == PH_SEARCH) begin
      if (b == CH_OPEN) begin
        parse_phase = PH_NUM1;
        cur_num = '0;
        ovf_seen = 1'b0;
      end
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      acc = int'(cur_num) * 10 + int'(b - CH_ZERO);
      if (acc > int'(SAT_MAX)) begin
        acc = int'(SAT_MAX);
        ovf_seen = 1'b1;
      end
      cur_num = acc[7:0];
    end else if (parse_phase != PH_NUM6) begin
      if (b == CH_COMMA) begin
        saved_nums[parse_phase - 1] = cur_num;
        cur_num = '0;
        parse_phase = phase_t'(parse_phase + 1);
      end
    end else if (b == CH_CLOSE) begin
      expected_addrs.push_back('{host_a: saved_nums[0], host_b: saved_nums[1],
                                 host_c: saved_nums[2], host_d: saved_nums[3],
                                 data_port: {saved_nums[4], cur_num},
                                 overflow: ovf_seen});
      parse_phase = PH_SEARCH;
      cur_num = '0;
      ovf_seen = 1'b0;
    end
  endfunction

  // Output side: ready pattern, with an occasional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    addr_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        addr_ch.ready <= 1'b0;
      end else begin
        addr_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && addr_ch.valid && addr_ch.ready) begin
      if (expected_addrs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none actual %0d.%0d.%0d.%0d:%0d ovf %0b",
                 $time, addr_ch.host_a, addr_ch.host_b, addr_ch.host_c,
                 addr_ch.host_d, addr_ch.data_port, addr_ch.overflow);
      end else begin
        exp_r = expected_addrs.pop_front();
        check_field("host_a", int'(exp_r.host_a), int'(addr_ch.host_a));
        check_field("host_b", int'(exp_r.host_b), int'(addr_ch.host_b));
        check_field("host_c", int'(exp_r.host_c), int'(addr_ch.host_c));
        check_field("host_d", int'(exp_r.host_d), int'(addr_ch.host_d));
        check_field("data_port", int'(exp_r.data_port), int'(addr_ch.data_port));
        check_field("overflow", int'(exp_r.overflow), int'(addr_ch.overflow));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    sent_bytes++;
    parse_reply_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    while (expected_addrs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random_number();
    int kind;
    int v;
    kind = $urandom_range(19);
    if (kind == 0) return;                          // empty number
    if (kind == 1) v = 0;
    else if (kind == 2) v = 255;
    else if (kind <= 4) v = $urandom_range(99999, 256);
    else v = $urandom_range(255);
    if (kind == 5) send_text("00");                 // leading zeros
    send_text($sformatf("%0d", v));
  endtask

  task automatic send_random_reply();
    int n;
    if ($urandom_range(3) == 0) send_text("227 Entering Passive Mode ");
    n = $urandom_range(3);
    repeat (n) send_byte(8'($urandom_range(255)));
    send_byte(CH_OPEN);
    for (int k = 0; k < 6; k++) begin
      if ($urandom_range(7) == 0) send_byte(8'($urandom_range(255)));
      if ($urandom_range(15) == 0) send_byte(k < 5 ? CH_CLOSE : CH_COMMA);
      if ($urandom_range(31) == 0) send_byte(CH_OPEN);
      send_random_number();
      if ($urandom_range(9) == 0) send_byte(" ");
      if (k < 5 && $urandom_range(29) != 0) send_byte(CH_COMMA);
    end
    if ($urandom_range(11) != 0) send_byte(CH_CLOSE);
    if ($urandom_range(1) == 0) send_text(".\r\n");
  endtask

  task automatic test_empty_and_max();
    send_text("A)(,,,,,)");
    send_text("(255,255,255,255,255,255)");
    wait_drained();
  endtask

  task automatic test_saturation_and_stray_separators();
    send_text("(9999,1,2(,3),4,5,6,)");
    send_text("(1,2,3,4,0,7)");
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 300;
    repeat (5) send_text("(10,20,30,40,50,60)");
    wait_drained();
  endtask

  task automatic test_random(input int s_pct, input int r_pct, input int n_bytes);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent_bytes = 0;
    while (sent_bytes < n_bytes) begin
      if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
      else send_random_reply();
    end
    wait_drained();
  endtask

  initial begin
    parse_phase = PH_SEARCH;
    cur_num = '0;
    ovf_seen = 1'b0;
    foreach (saved_nums[i]) saved_nums[i] = '0;
    mismatches = 0;
    sent_bytes = 0;
    send_idle_pct = 12;
    recv_idle_pct = 57;
    hold_request = 0;
    rst <= 1'b1;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_max();
    test_saturation_and_stray_separators();
    test_random(12, 57, 480);
    test_backpressure();
    test_random(57, 12, 480);
    test_random(0, 0, 480);

    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("ftp_passive_reply_parser_unit_test passed");
    end else begin
      $display("ftp_passive_reply_parser_unit_test failed");
    end
    $finish;
  end

endmodule

// ===== ftp_passive_reply_parser_unit.f =====
rtl/fprp_pkg.sv
rtl/fprp_if.sv
rtl/fprp_in_reg.sv
rtl/fprp_parse.sv
rtl/fprp_out_reg.sv
rtl/ftp_passive_reply_parser_unit.sv
test/ftp_passive_reply_parser_unit_test.sv
